FILE: rtl/log_binned_constant_histogram_assert.svh
// Assertion macros for the log-binned constant histogram.
// Used by the top level, which checks its own logic; no other dependencies.
`ifndef LOG_BINNED_CONSTANT_HISTOGRAM_ASSERT_SVH
`define LOG_BINNED_CONSTANT_HISTOGRAM_ASSERT_SVH

`ifndef SYNTHESIS
// Property prop must hold at every clock edge outside reset.
`define LBCH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition cond must never be true at a clock edge outside reset.
`define LBCH_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LBCH_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBCH_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/lbch_pkg.sv
// Shared types and constants of the log-binned constant histogram.
// No dependencies; imported by the interfaces and all modules.
package lbch_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned BinIdxW  = 7;
  localparam int unsigned CounterW = 32;
  localparam int unsigned IncW     = 17;

  // Weight added on top of the occurrence count.
  localparam logic [IncW-1:0] WeightBias = 17'd1000;

  // Largest value that has a bin of its own.
  localparam logic [6:0] SmallMax = 7'd64;

  localparam logic signed [ValueW-1:0] DontCareVal = -32'sd2;
  localparam logic signed [ValueW-1:0] HighZVal    = -32'sd3;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [ValueW-1:0]  constant_value;
    logic [CountW-1:0]         occurrence_count;
    logic [BinIdxW-1:0]        read_bin;
  } lbch_in_t;

  typedef struct packed {
    logic [BinIdxW-1:0]  bin_index;
    logic [CounterW-1:0] bin_value;
  } lbch_out_t;

endpackage

FILE: rtl/lbch_intf.sv
// Valid/ready channel interfaces for the histogram's input and result streams.
// Depends on lbch_pkg for the payload types.
interface lbch_in_if
  import lbch_pkg::*;
();
  logic     valid;
  logic     ready;
  lbch_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbch_out_if
  import lbch_pkg::*;
();
  logic      valid;
  logic      ready;
  lbch_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/log_binned_constant_histogram.sv
// Top level of the log-binned constant histogram: counter memory and update pipe.
// Depends on lbch_pkg, lbch_intf, lbch_bin_map and the assertion macro header.
//
//   Channel | Dir | Payload                                            | Transfer
//   in_i    | in  | kind, constant_value, occurrence_count, read_bin   | valid & ready
//   out_o   | out | bin_index, bin_value                               | valid & ready
//
// One item per cycle unless out_o stalls; each item passes s1, then out_q.
// The bin is chosen and the counter memory read in the accept cycle; the add and
// write-back happen once the item leaves s1, with the value just written forwarded
// to a read of the same bin issued at the same edge.
// Reset clears per-bin valid bits at once, so no clearing pass is needed.
// A stalled result register holds the whole pipe; in_i.ready follows it.
`include "log_binned_constant_histogram_assert.svh"

module log_binned_constant_histogram
  import lbch_pkg::*;
#(
  parameter int unsigned NUM_BINS = 94
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbch_in_if.sink    in_i,
  lbch_out_if.source out_o
);

  localparam int unsigned TotalBins = NUM_BINS + 2;
  localparam int unsigned BinW      = $clog2(TotalBins);

  logic [CounterW-1:0] cnt_mem [TotalBins];
  logic [TotalBins-1:0] bin_valid_q;

  logic            advance;
  logic            accept;
  logic [BinW-1:0] add_bin;
  logic [BinW-1:0] rd_addr;
  logic            rd_oor;
  logic            rd_en;

  logic                s1_valid_q;
  kind_e               s1_kind_q;
  logic [BinW-1:0]     s1_bin_q;
  logic [BinIdxW-1:0]  s1_index_q;
  logic [IncW-1:0]     s1_inc_q;
  logic                s1_oor_q;
  logic                s1_hit_q;
  logic [CounterW-1:0] fwd_val_q;
  logic [CounterW-1:0] rdata_q;
  logic                rvalid_q;

  logic [CounterW-1:0] old_val;
  logic [CounterW-1:0] new_val;
  logic                wr_en;
  lbch_out_t           result;

  logic      out_valid_q;
  lbch_out_t out_q;

  lbch_bin_map #(
    .NUM_BINS(NUM_BINS)
  ) u_bin_map (
    .value_i(in_i.data.constant_value),
    .bin_o  (add_bin)
  );

  assign advance    = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && advance;
  assign in_i.ready = advance;

  assign rd_oor  = (in_i.data.kind == KIND_READ) &&
                   ((BinW+1)'(in_i.data.read_bin) >= (BinW+1)'(TotalBins));
  assign rd_addr = (in_i.data.kind == KIND_ADD) ? add_bin : BinW'(in_i.data.read_bin);
  assign rd_en   = accept && !rd_oor;

  // A counter never written since reset reads as zero.
  assign old_val = s1_hit_q ? fwd_val_q : (rvalid_q ? rdata_q : '0);
  assign new_val = old_val + CounterW'(s1_inc_q);
  assign wr_en   = advance && s1_valid_q && (s1_kind_q == KIND_ADD);

  always_comb begin
    result.bin_index = s1_index_q;
    if (s1_kind_q == KIND_ADD) begin
      result.bin_value = new_val;
    end else if (s1_oor_q) begin
      result.bin_value = '0;
    end else begin
      result.bin_value = old_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bin_valid_q <= '0;
    end else begin
      if (advance) begin
        s1_valid_q  <= accept;
        out_valid_q <= s1_valid_q;
      end
      if (wr_en) begin
        bin_valid_q[s1_bin_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= in_i.data.kind;
      s1_bin_q   <= rd_addr;
      s1_index_q <= (in_i.data.kind == KIND_ADD) ? BinIdxW'(add_bin) : in_i.data.read_bin;
      s1_inc_q   <= IncW'(in_i.data.occurrence_count) + WeightBias;
      s1_oor_q   <= rd_oor;
      s1_hit_q   <= rd_en && wr_en && (s1_bin_q == rd_addr);
      fwd_val_q  <= new_val;
    end
    if (rd_en) begin
      rdata_q  <= cnt_mem[rd_addr];
      rvalid_q <= bin_valid_q[rd_addr];
    end
    if (wr_en) begin
      cnt_mem[s1_bin_q] <= new_val;
    end
    if (advance && s1_valid_q) begin
      out_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `LBCH_ASSERT_NEVER(a_wr_in_range, clk_i, rst_ni, wr_en && ({1'b0, s1_bin_q} >= (BinW+1)'(TotalBins)), "write beyond the last bin")
  `LBCH_ASSERT(a_accept_fills_s1, clk_i, rst_ni, accept |=> s1_valid_q, "accepted item lost before the memory stage")
  `LBCH_ASSERT(a_stall_holds_s1, clk_i, rst_ni, (!advance && s1_valid_q) |=> (s1_valid_q && $stable(s1_bin_q)), "memory stage changed during a stall")
  `LBCH_ASSERT_NEVER(a_no_write_on_read, clk_i, rst_ni, wr_en && (s1_kind_q == KIND_READ), "read item wrote a counter")

endmodule

FILE: rtl/lbch_bin_map.sv
// Maps a signed constant to its histogram bin (priority encode of the top bit).
// Depends on lbch_pkg.
module lbch_bin_map
  import lbch_pkg::*;
#(
  parameter int unsigned NUM_BINS = 94
) (
  input  logic signed [ValueW-1:0]          value_i,
  output logic [$clog2(NUM_BINS+2)-1:0]     bin_o
);

  localparam int unsigned BinW = $clog2(NUM_BINS + 2);
  localparam logic [7:0]  LastLogBin = 8'(NUM_BINS - 2);

  logic       is_small;
  logic       is_pow2;
  logic [4:0] msb_pos;
  logic [6:0] log_bin;

  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < ValueW - 1; i++) begin
      if (value_i[i]) begin
        msb_pos = 5'(i);
      end
    end
  end

  assign is_small = !value_i[ValueW-1] && (value_i[ValueW-2:7] == '0) &&
                    (value_i[6:0] <= SmallMax);
  assign is_pow2  = ((value_i & (value_i - 32'sd1)) == '0);

  // Between two powers: bin 2k+53; exactly a power 2^k: bin 2k+52.
  assign log_bin = 7'({msb_pos, 1'b0}) + 7'd52 + 7'(!is_pow2);

  always_comb begin
    if (value_i == DontCareVal) begin
      bin_o = BinW'(NUM_BINS);
    end else if (value_i == HighZVal) begin
      bin_o = BinW'(NUM_BINS + 1);
    end else if (value_i[ValueW-1]) begin
      bin_o = BinW'(NUM_BINS - 1);
    end else if (is_small) begin
      bin_o = BinW'(value_i[6:0]);
    end else if (8'(log_bin) > LastLogBin) begin
      bin_o = BinW'(NUM_BINS - 1);
    end else begin
      bin_o = BinW'(log_bin);
    end
  end

endmodule
